// File: design/dqbf_pkg.sv
// ----------------------------------------------------------------------------
// dqbf_pkg
// Shared types and constants of the detection query box filter.
// ----------------------------------------------------------------------------
`default_nettype none

package dqbf_pkg;

    localparam int NetW    = 13;
    localparam int MaskW   = 11;
    localparam int ThrW    = 17;
    localparam int ScoreW  = 16;
    localparam int CoordW  = 21;
    localparam int WordW   = 32;
    localparam int OpW     = 34;
    localparam int MultW   = 14;
    localparam int ProdW   = 50;
    localparam int DataW   = 144;
    localparam int FifoDepth = 4;
    localparam int FifoPtrW  = 2;

    // normalized corner window, Q16.16
    localparam logic signed [WordW-1:0] NormLo = -32'sd32768;
    localparam logic signed [WordW-1:0] NormHi = 32'sd98304;

    typedef enum logic [2:0] {
        REG_NET_WIDTH       = 3'd0,
        REG_NET_HEIGHT      = 3'd1,
        REG_MASK_COLS       = 3'd2,
        REG_MASK_ROWS       = 3'd3,
        REG_SCORE_THRESHOLD = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        DROP_NONE  = 2'd0,
        DROP_SCORE = 2'd1,
        DROP_SMALL = 2'd2
    } drop_t;

    typedef struct packed {
        logic [NetW-1:0]  net_width;
        logic [NetW-1:0]  net_height;
        logic [MaskW-1:0] mask_cols;
        logic [MaskW-1:0] mask_rows;
        logic [ThrW-1:0]  score_threshold;
    } cfg_t;

    // decoded query between front and back, corners in signed Q33.17 pixels
    typedef struct packed {
        logic [ScoreW-1:0]       score;
        logic                    low;
        logic signed [ProdW-1:0] x1;
        logic signed [ProdW-1:0] y1;
        logic signed [ProdW-1:0] x2;
        logic signed [ProdW-1:0] y2;
    } fq_t;

endpackage

`default_nettype wire

// File: design/dqbf_front.sv
// ----------------------------------------------------------------------------
// dqbf_front
// Accepts queries, looks up the score, classifies and decodes the box.
// ----------------------------------------------------------------------------
`default_nettype none

module dqbf_front
    import dqbf_pkg::*;
#(
    parameter int SIGMOID_TABLE_SIZE = 1024
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cfg_t             cfg,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [DataW-1:0] in_data,
    input  wire logic             room,
    output logic                  wr_en,
    output fq_t                   wr_data
);

    localparam int IdxW = $clog2(SIGMOID_TABLE_SIZE);
    localparam int MagProdW = 34;

    // entry k in bits [16k +: 16]
    typedef logic [SIGMOID_TABLE_SIZE*ScoreW-1:0] sig_rom_t;

    // long division for the table build, evaluated at elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, dvs})
            begin
                rem  = rem - {1'b0, dvs};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] exp_frac(input logic [63:0] f);
        logic [63:0] sum;
        logic [63:0] term;
        sum  = 64'd1 << 24;
        term = 64'd1 << 24;
        for (int i = 1; i <= 14; i++) begin
            term = udiv64(term * f, 64'(i) << 24);
            sum  = sum + term;
        end
        return sum;
    endfunction

    function automatic sig_rom_t build_rom();
        sig_rom_t    rom;
        logic [63:0] e_q;
        logic [63:0] t;
        logic [63:0] n;
        logic [63:0] ef;
        logic [63:0] d;
        logic [63:0] den;
        logic [63:0] s;
        rom = '0;
        e_q = exp_frac(64'd1 << 24);
        for (int k = 0; k < SIGMOID_TABLE_SIZE; k++) begin
            t  = udiv64(64'(k) * (64'd16 << 24), 64'(SIGMOID_TABLE_SIZE));
            n  = t >> 24;
            ef = exp_frac(t & 64'hFF_FFFF);
            d  = udiv64(64'd1 << 56, ef);
            for (int j = 0; j < 16; j++) begin
                if (64'(j) < n)
                begin
                    d = udiv64(d << 24, e_q);
                end
            end
            den = (64'd1 << 32) + d;
            s   = udiv64((64'd1 << 48) + (den >> 1), den);
            rom[k*ScoreW +: ScoreW] = (s > 64'd65535) ? 16'hFFFF : s[15:0];
        end
        return rom;
    endfunction

    localparam sig_rom_t SIG_ROM = build_rom();

    logic signed [15:0]       logit;
    logic signed [WordW-1:0]  a;
    logic signed [WordW-1:0]  b;
    logic signed [WordW-1:0]  c;
    logic signed [WordW-1:0]  d;
    logic [15:0]              mag;
    logic [MagProdW-1:0]      idx_full;
    logic [IdxW-1:0]          idx;
    logic                     corner;
    logic                     norm;
    logic                     en;

    logic                     f1_valid_reg;
    logic [ScoreW-1:0]        tab_reg;
    logic                     neg_reg;
    logic                     corner_reg;
    logic                     norm_reg;
    logic signed [OpW-1:0]    op_reg [4];

    logic [ThrW-1:0]          score_raw;
    logic [ScoreW-1:0]        score;
    logic [MultW-1:0]         mult_x;
    logic [MultW-1:0]         mult_y;

    assign logit = in_data[15:0];
    assign a     = in_data[47:16];
    assign b     = in_data[79:48];
    assign c     = in_data[111:80];
    assign d     = in_data[143:112];

    assign mag      = logit[15] ? 16'(-logit) : 16'(logit);
    assign idx_full = (MagProdW'(mag) * MagProdW'(SIGMOID_TABLE_SIZE)) >> 12;
    assign idx      = (idx_full > MagProdW'(SIGMOID_TABLE_SIZE - 1))
                      ? IdxW'(SIGMOID_TABLE_SIZE - 1) : idx_full[IdxW-1:0];

    assign corner = (c > a) && (d > b);
    assign norm   = (a >= NormLo) && (b >= NormLo) && (c <= NormHi) && (d <= NormHi);

    assign en       = !f1_valid_reg || room;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            tab_reg    <= SIG_ROM[{idx, 4'b0} +: ScoreW];
            neg_reg    <= logit[15];
            corner_reg <= corner;
            norm_reg   <= norm;
            if (corner)
            begin
                op_reg[0] <= OpW'(a);
                op_reg[1] <= OpW'(b);
                op_reg[2] <= OpW'(c);
                op_reg[3] <= OpW'(d);
            end
            else
            begin
                op_reg[0] <= (OpW'(a) <<< 1) - OpW'(c);
                op_reg[1] <= (OpW'(b) <<< 1) - OpW'(d);
                op_reg[2] <= (OpW'(a) <<< 1) + OpW'(c);
                op_reg[3] <= (OpW'(b) <<< 1) + OpW'(d);
            end
        end
    end

    always_comb
    begin
        score_raw = neg_reg ? (17'd65536 - ThrW'(tab_reg)) : ThrW'(tab_reg);
        score     = (score_raw > 17'd65535) ? 16'hFFFF : score_raw[15:0];
        // scale: 2*net for normalized corners, 2 for pixel corners, net for center form
        if (corner_reg)
        begin
            mult_x = norm_reg ? {cfg.net_width, 1'b0}  : MultW'(2);
            mult_y = norm_reg ? {cfg.net_height, 1'b0} : MultW'(2);
        end
        else
        begin
            mult_x = MultW'(cfg.net_width);
            mult_y = MultW'(cfg.net_height);
        end
    end

    assign wr_en         = f1_valid_reg && room;
    assign wr_data.score = score;
    assign wr_data.low   = ThrW'(score) < cfg.score_threshold;
    assign wr_data.x1    = ProdW'(op_reg[0]) * ProdW'($signed({1'b0, mult_x}));
    assign wr_data.y1    = ProdW'(op_reg[1]) * ProdW'($signed({1'b0, mult_y}));
    assign wr_data.x2    = ProdW'(op_reg[2]) * ProdW'($signed({1'b0, mult_x}));
    assign wr_data.y2    = ProdW'(op_reg[3]) * ProdW'($signed({1'b0, mult_y}));

endmodule

`default_nettype wire

// File: design/dqbf_fifo.sv
// ----------------------------------------------------------------------------
// dqbf_fifo
// Short queue of decoded queries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module dqbf_fifo
    import dqbf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire fq_t  wr_data,
    output logic      room,
    input  wire logic rd_en,
    output fq_t       rd_data,
    output logic      nonempty
);

    fq_t                mem [FifoDepth];
    logic [FifoPtrW-1:0] wp_reg;
    logic [FifoPtrW-1:0] rp_reg;
    logic [FifoPtrW:0]   count_reg;

    assign room     = count_reg != (FifoPtrW+1)'(FifoDepth);
    assign nonempty = count_reg != '0;
    assign rd_data  = mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (rd_en)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: design/dqbf_back.sv
// ----------------------------------------------------------------------------
// dqbf_back
// Clamps the box, checks its size and works out the mask crop.
// ----------------------------------------------------------------------------
`default_nettype none

module dqbf_back
    import dqbf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cfg_t             cfg,
    input  wire logic             nonempty,
    input  wire fq_t              head,
    output logic                  pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [DataW-1:0]      out_data,
    output logic [2:0]            out_user
);

    localparam int QW     = 11;
    localparam int Steps  = QW;
    localparam int RemW   = 33;
    localparam int NumW   = 32;
    localparam int DenW   = 21;

    typedef struct packed {
        logic [ScoreW-1:0] score;
        drop_t             reason;
        logic [CoordW-1:0] l;
        logic [CoordW-1:0] t;
        logic [CoordW-1:0] w;
        logic [CoordW-1:0] h;
    } side_t;

    function automatic logic [CoordW-1:0] clamp_px(input logic signed [ProdW-1:0] v,
                                                   input logic [NetW-1:0] net);
        logic [29:0] lim;
        lim = {net, 17'b0};
        if (v < 0)
        begin
            return '0;
        end
        else if (v > $signed({20'b0, lim}))
        begin
            return lim[29:9];
        end
        return v[29:9];
    endfunction

    logic             en;
    logic [MaskW-1:0] mx;
    logic [MaskW-1:0] my;
    logic [DenW-1:0]  den_l [4];

    // p1: clamped corners
    logic              p1_valid_reg;
    logic [ScoreW-1:0] p1_score_reg;
    logic              p1_low_reg;
    logic [CoordW-1:0] p1_l_reg;
    logic [CoordW-1:0] p1_t_reg;
    logic [CoordW-1:0] p1_r_reg;
    logic [CoordW-1:0] p1_b_reg;

    // p2: size check and crop numerators
    logic              p2_valid_reg;
    side_t             p2_side_reg;
    logic [NumW-1:0]   p2_num_reg [4];
    logic [CoordW-1:0] w_next;
    logic [CoordW-1:0] h_next;

    // divider pipe, lanes: x start, x end, y start, y end
    logic              dv_valid_reg [Steps+1];
    side_t             dv_side_reg  [Steps+1];
    logic [RemW-1:0]   dv_rem_reg   [Steps+1][4];
    logic [QW-1:0]     dv_q_reg     [Steps+1][4];

    logic              ov_reg;
    side_t             os_reg;
    logic [9:0]        ocol_reg;
    logic [9:0]        orow_reg;
    logic [QW-1:0]     ocols_reg;
    logic [QW-1:0]     orows_reg;

    logic [QW-1:0]     s_x, e_x, s_y, e_y;

    function automatic logic [MaskW-1:0] sat_mask(input logic [MaskW-1:0] m);
        if (m == '0)
        begin
            return MaskW'(1);
        end
        else if (m > MaskW'(1024))
        begin
            return MaskW'(1024);
        end
        return m;
    endfunction

    // first and count of one crop axis from the two quotients
    function automatic logic [2*QW-1:0] crop_fix(input logic [QW-1:0] qs,
                                                 input logic [QW-1:0] qe,
                                                 input logic [MaskW-1:0] m);
        logic [QW-1:0] s;
        logic [QW-1:0] e;
        s = (qs > m - 1'b1) ? m - 1'b1 : qs;
        e = (qe < s + 1'b1) ? s + 1'b1 : qe;
        e = (e > m) ? m : e;
        return {s, QW'(e - s)};
    endfunction

    assign en  = !ov_reg || out_ready;
    assign pop = en && nonempty;
    assign mx  = sat_mask(cfg.mask_cols);
    assign my  = sat_mask(cfg.mask_rows);
    assign den_l[0] = {cfg.net_width, 8'b0};
    assign den_l[1] = {cfg.net_width, 8'b0};
    assign den_l[2] = {cfg.net_height, 8'b0};
    assign den_l[3] = {cfg.net_height, 8'b0};

    assign w_next = (p1_r_reg > p1_l_reg) ? p1_r_reg - p1_l_reg : '0;
    assign h_next = (p1_b_reg > p1_t_reg) ? p1_b_reg - p1_t_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            dv_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg    <= nonempty;
            p2_valid_reg    <= p1_valid_reg;
            dv_valid_reg[0] <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_score_reg <= head.score;
            p1_low_reg   <= head.low;
            p1_l_reg     <= clamp_px(head.x1, cfg.net_width);
            p1_t_reg     <= clamp_px(head.y1, cfg.net_height);
            p1_r_reg     <= clamp_px(head.x2, cfg.net_width);
            p1_b_reg     <= clamp_px(head.y2, cfg.net_height);

            p2_side_reg.score <= p1_score_reg;
            p2_side_reg.l     <= p1_l_reg;
            p2_side_reg.t     <= p1_t_reg;
            p2_side_reg.w     <= w_next;
            p2_side_reg.h     <= h_next;
            if (p1_low_reg)
            begin
                p2_side_reg.reason <= DROP_SCORE;
            end
            else if (w_next < CoordW'(256) || h_next < CoordW'(256))
            begin
                p2_side_reg.reason <= DROP_SMALL;
            end
            else
            begin
                p2_side_reg.reason <= DROP_NONE;
            end
            p2_num_reg[0] <= NumW'(p1_l_reg) * NumW'(mx);
            p2_num_reg[1] <= NumW'(p1_r_reg) * NumW'(mx);
            p2_num_reg[2] <= NumW'(p1_t_reg) * NumW'(my);
            p2_num_reg[3] <= NumW'(p1_b_reg) * NumW'(my);

            // end lanes round up
            dv_side_reg[0]   <= p2_side_reg;
            dv_rem_reg[0][0] <= RemW'(p2_num_reg[0]);
            dv_rem_reg[0][1] <= RemW'(p2_num_reg[1]) + RemW'(den_l[1]) - 1'b1;
            dv_rem_reg[0][2] <= RemW'(p2_num_reg[2]);
            dv_rem_reg[0][3] <= RemW'(p2_num_reg[3]) + RemW'(den_l[3]) - 1'b1;
            for (int j = 0; j < 4; j++)
            begin
                dv_q_reg[0][j] <= '0;
            end
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < Steps; k++)
    begin : g_div
        localparam int Bit = Steps - 1 - k;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_side_reg[k+1] <= dv_side_reg[k];
                for (int j = 0; j < 4; j++)
                begin
                    if (dv_rem_reg[k][j] >= (RemW'(den_l[j]) << Bit))
                    begin
                        dv_rem_reg[k+1][j] <= dv_rem_reg[k][j] - (RemW'(den_l[j]) << Bit);
                        dv_q_reg[k+1][j]   <= dv_q_reg[k][j] | (QW'(1) << Bit);
                    end
                    else
                    begin
                        dv_rem_reg[k+1][j] <= dv_rem_reg[k][j];
                        dv_q_reg[k+1][j]   <= dv_q_reg[k][j];
                    end
                end
            end
        end
    end

    assign {s_x, e_x} = crop_fix(dv_q_reg[Steps][0], dv_q_reg[Steps][1], mx);
    assign {s_y, e_y} = crop_fix(dv_q_reg[Steps][2], dv_q_reg[Steps][3], my);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            ov_reg <= dv_valid_reg[Steps];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            os_reg.score  <= dv_side_reg[Steps].score;
            os_reg.reason <= dv_side_reg[Steps].reason;
            if (dv_side_reg[Steps].reason != DROP_NONE)
            begin
                os_reg.l  <= '0;
                os_reg.t  <= '0;
                os_reg.w  <= '0;
                os_reg.h  <= '0;
                ocol_reg  <= '0;
                orow_reg  <= '0;
                ocols_reg <= '0;
                orows_reg <= '0;
            end
            else
            begin
                os_reg.l  <= dv_side_reg[Steps].l;
                os_reg.t  <= dv_side_reg[Steps].t;
                os_reg.w  <= dv_side_reg[Steps].w;
                os_reg.h  <= dv_side_reg[Steps].h;
                ocol_reg  <= s_x[9:0];
                orow_reg  <= s_y[9:0];
                ocols_reg <= e_x;
                orows_reg <= e_y;
            end
        end
    end

    assign out_valid = ov_reg;
    assign out_user  = {os_reg.reason, os_reg.reason == DROP_NONE};
    assign out_data  = {2'b0, orows_reg, ocols_reg, orow_reg, ocol_reg,
                        os_reg.h, os_reg.w, os_reg.t, os_reg.l, os_reg.score};

endmodule

`default_nettype wire

// File: design/detection_query_box_filter.sv
// ----------------------------------------------------------------------------
// detection_query_box_filter
// One result item per detector query: sigmoid score with a threshold, box
// decode (normalized corners, pixel corners or center and size), clamp to
// the frame, a one-pixel size check and the mask crop rectangle. One item
// is taken per clock and one result leaves per clock when the output side
// is ready; an item passes the front register for the table read, the
// queue, whose write carries the scaling multiply, three back stages for
// clamp, size check and crop rounding, 11 stages of the one-bit-per-stage
// crop divider, and the output register. Dropped items carry the score
// and the reason and zero box and crop fields. The sigmoid table is a ROM
// of SIGMOID_TABLE_SIZE entries built at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

module detection_query_box_filter
    import dqbf_pkg::*;
#(
    parameter int SIGMOID_TABLE_SIZE = 1024
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [ThrW-1:0]  cfg_data,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    // class_logit, box_a, box_b, box_c, box_d
    input  wire logic [DataW-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // score, out_left, out_top, out_width, out_height, crop_col, crop_row,
    // crop_cols, crop_rows, 2 bits zero pad
    output logic [DataW-1:0]      m_axis_tdata,
    // keep, drop_reason
    output logic [2:0]            m_axis_tuser
);

    cfg_t cfg_reg;
    logic room;
    logic wr_en;
    fq_t  wr_data;
    logic pop;
    fq_t  head;
    logic nonempty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.net_width       <= NetW'(640);
            cfg_reg.net_height      <= NetW'(640);
            cfg_reg.mask_cols       <= MaskW'(160);
            cfg_reg.mask_rows       <= MaskW'(160);
            cfg_reg.score_threshold <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_NET_WIDTH:       cfg_reg.net_width       <= cfg_data[NetW-1:0];
                REG_NET_HEIGHT:      cfg_reg.net_height      <= cfg_data[NetW-1:0];
                REG_MASK_COLS:       cfg_reg.mask_cols       <= cfg_data[MaskW-1:0];
                REG_MASK_ROWS:       cfg_reg.mask_rows       <= cfg_data[MaskW-1:0];
                REG_SCORE_THRESHOLD: cfg_reg.score_threshold <= cfg_data;
                default:             ;
            endcase
        end
    end

    dqbf_front #(
        .SIGMOID_TABLE_SIZE (SIGMOID_TABLE_SIZE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .room     (room),
        .wr_en    (wr_en),
        .wr_data  (wr_data)
    );

    dqbf_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_data  (wr_data),
        .room     (room),
        .rd_en    (pop),
        .rd_data  (head),
        .nonempty (nonempty)
    );

    dqbf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .nonempty  (nonempty),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// File: tb/detection_query_box_filter_tb.sv
// ----------------------------------------------------------------------------
// detection_query_box_filter_tb
// Streams detector queries into the box filter and checks every result item
// field by field against a predictor that computes the sigmoid score, the
// threshold, the box decode and clamp and the mask crop. Several register
// settings are used, extremes among them, random stalls on both sides for the first four.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module detection_query_box_filter_tb;
    import dqbf_pkg::*;

    localparam int TableSize = 1024;
    localparam int WatchdogLimit = 5000;
    localparam int ItemsPerSetting = 280;

    typedef struct packed {
        logic          keep;
        drop_t         reason;
        logic [15:0]   score;
        logic [20:0]   left;
        logic [20:0]   top;
        logic [20:0]   width;
        logic [20:0]   height;
        logic [9:0]    crop_col;
        logic [9:0]    crop_row;
        logic [10:0]   crop_cols;
        logic [10:0]   crop_rows;
    } result_t;

    typedef struct {
        logic signed [15:0] logit;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic               known;
        drop_t              known_reason;
        logic [15:0]        known_score;
    } query_row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [2:0]       cfg_index;
    logic [ThrW-1:0]  cfg_data;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [DataW-1:0] s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [DataW-1:0] m_axis_tdata;
    logic [2:0]       m_axis_tuser;

    detection_query_box_filter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // predictor copy of the registers
    longint unsigned net_w;
    longint unsigned net_h;
    longint unsigned mask_c;
    longint unsigned mask_r;
    longint unsigned thresh;
    longint unsigned sigmoid_rom [TableSize];

    result_t pending_results [$];
    int      error_count;
    int      idle_cycles;
    int      sender_idle_pct;
    int      receiver_idle_pct;
    int      kept_count;
    int      score_drop_count;
    int      small_drop_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned exp_fraction(longint unsigned f);
        longint unsigned sum;
        longint unsigned term;
        sum = 64'd1 << 24;
        term = 64'd1 << 24;
        for (longint unsigned i = 1; i <= 14; i++)
        begin
            term = (term * f) / (i << 24);
            sum += term;
        end
        return sum;
    endfunction

    function automatic void build_sigmoid_rom();
        longint unsigned e_q;
        longint unsigned t;
        longint unsigned dv;
        longint unsigned den;
        longint unsigned s;
        e_q = exp_fraction(64'd1 << 24);
        for (longint unsigned k = 0; k < TableSize; k++)
        begin
            t = (k * (64'd16 << 24)) / TableSize;
            dv = (64'd1 << 56) / exp_fraction(t & ((64'd1 << 24) - 1));
            for (longint unsigned j = 0; j < (t >> 24); j++)
                dv = (dv << 24) / e_q;
            den = (64'd1 << 32) + dv;
            s = ((64'd1 << 48) + den / 2) / den;
            sigmoid_rom[k] = (s > 65535) ? 65535 : s;
        end
    endfunction

    function automatic longint unsigned clamp_to_frame(longint v, longint unsigned px);
        longint lim;
        lim = longint'(px) * 131072;
        if (v < 0)
            v = 0;
        if (v > lim)
            v = lim;
        return longint'(unsigned'(v)) >>> 9;
    endfunction

    function automatic void crop_span(longint unsigned lo, longint unsigned len,
                                      longint unsigned net, longint unsigned mdim,
                                      output longint unsigned first,
                                      output longint unsigned count);
        longint unsigned den;
        longint unsigned m;
        longint unsigned s;
        longint unsigned e;
        den = net * 256;
        m = (mdim < 1) ? 1 : ((mdim > 1024) ? 1024 : mdim);
        s = (lo * m) / den;
        e = ((lo + len) * m + den - 1) / den;
        if (s > m - 1)
            s = m - 1;
        if (e < s + 1)
            e = s + 1;
        if (e > m)
            e = m;
        first = s;
        count = e - s;
    endfunction

    function automatic result_t filter_query(logic signed [15:0] logit,
                                             logic signed [31:0] a, logic signed [31:0] b,
                                             logic signed [31:0] c, logic signed [31:0] d);
        result_t r;
        longint mag;
        longint unsigned idx;
        longint unsigned sc;
        longint x1;
        longint y1;
        longint x2;
        longint y2;
        longint nw;
        longint nh;
        longint unsigned l;
        longint unsigned t;
        longint unsigned rt;
        longint unsigned bt;
        longint unsigned w;
        longint unsigned h;
        longint unsigned cc;
        longint unsigned cr;
        longint unsigned ncc;
        longint unsigned ncr;
        r = '{keep: 1'b0, reason: DROP_NONE, default: '0};
        mag = (logit < 0) ? -longint'(logit) : longint'(logit);
        idx = (longint'(mag) * TableSize) / 4096;
        if (idx >= TableSize)
            idx = TableSize - 1;
        sc = (logit < 0) ? 65536 - sigmoid_rom[idx] : sigmoid_rom[idx];
        if (sc > 65535)
            sc = 65535;
        r.score = sc[15:0];
        if (sc < thresh)
        begin
            r.reason = DROP_SCORE;
            return r;
        end
        nw = longint'(net_w);
        nh = longint'(net_h);
        if (c > a && d > b)
        begin
            if (a >= NormLo && b >= NormLo && c <= NormHi && d <= NormHi)
            begin
                x1 = a * nw * 2;
                y1 = b * nh * 2;
                x2 = c * nw * 2;
                y2 = d * nh * 2;
            end
            else
            begin
                x1 = longint'(a) * 2;
                y1 = longint'(b) * 2;
                x2 = longint'(c) * 2;
                y2 = longint'(d) * 2;
            end
        end
        else
        begin
            x1 = (2 * longint'(a) - c) * nw;
            y1 = (2 * longint'(b) - d) * nh;
            x2 = (2 * longint'(a) + c) * nw;
            y2 = (2 * longint'(b) + d) * nh;
        end
        l = clamp_to_frame(x1, net_w);
        t = clamp_to_frame(y1, net_h);
        rt = clamp_to_frame(x2, net_w);
        bt = clamp_to_frame(y2, net_h);
        w = (rt > l) ? rt - l : 0;
        h = (bt > t) ? bt - t : 0;
        if (w < 256 || h < 256)
        begin
            r.reason = DROP_SMALL;
            return r;
        end
        crop_span(l, w, net_w, mask_c, cc, ncc);
        crop_span(t, h, net_h, mask_r, cr, ncr);
        r.keep = 1'b1;
        r.left = l[20:0];
        r.top = t[20:0];
        r.width = w[20:0];
        r.height = h[20:0];
        r.crop_col = cc[9:0];
        r.crop_row = cr[9:0];
        r.crop_cols = ncc[10:0];
        r.crop_rows = ncr[10:0];
        return r;
    endfunction

    task automatic write_reg(cfg_index_t idx, int unsigned value);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = value[ThrW-1:0];
        @(negedge clk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_NET_WIDTH:       net_w = value & 32'h1FFF;
            REG_NET_HEIGHT:      net_h = value & 32'h1FFF;
            REG_MASK_COLS:       mask_c = value & 32'h7FF;
            REG_MASK_ROWS:       mask_r = value & 32'h7FF;
            REG_SCORE_THRESHOLD: thresh = value & 32'h1FFFF;
            default: ;
        endcase
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (25) @(negedge clk);
    endtask

    task automatic apply_setting(int unsigned nw, int unsigned nh, int unsigned mc,
                                 int unsigned mr, int unsigned thr);
        drain_results();
        write_reg(REG_NET_WIDTH, nw);
        write_reg(REG_NET_HEIGHT, nh);
        write_reg(REG_MASK_COLS, mc);
        write_reg(REG_MASK_ROWS, mr);
        write_reg(REG_SCORE_THRESHOLD, thr);
    endtask

    task automatic send_query(logic signed [15:0] logit, logic signed [31:0] a,
                              logic signed [31:0] b, logic signed [31:0] c,
                              logic signed [31:0] d);
        logic taken;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {d, c, b, a, logit};
        pending_results.push_back(filter_query(logit, a, b, c, d));
        // tready only moves at rising edges, so the falling-edge value holds
        taken = s_axis_tready;
        @(posedge clk);
        while (!taken)
        begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
        end
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    function automatic logic signed [31:0] pixel_word(longint unsigned span);
        longint v;
        v = longint'($urandom_range(span + 200)) - 100;
        return 32'(v * 65536 + $urandom_range(65535));
    endfunction

    task automatic send_random_query();
        logic signed [15:0] logit;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        int kind;
        logit = ($urandom_range(3) == 0) ? 16'($urandom_range(3000)) - 16'sd1500
                                         : 16'($urandom);
        kind = $urandom_range(9);
        if (kind < 3)
        begin
            // normalized corners
            a = 32'($urandom_range(131072)) - 32'sd32768;
            b = 32'($urandom_range(131072)) - 32'sd32768;
            c = a + 32'($urandom_range(32'(98304 - a)));
            d = b + 32'($urandom_range(32'(98304 - b)));
        end
        else if (kind < 6)
        begin
            // pixel corners
            a = pixel_word(net_w);
            b = pixel_word(net_h);
            c = a + 32'($urandom_range(32'd1 << ($urandom_range(4, 27))));
            d = b + 32'($urandom_range(32'd1 << ($urandom_range(4, 27))));
        end
        else if (kind < 9)
        begin
            // center and size, size not above center keeps it out of corner form
            a = 32'($urandom_range(65536));
            b = 32'($urandom_range(65536));
            c = 32'($urandom_range(a));
            d = 32'($urandom_range(b));
        end
        else
        begin
            a = $urandom;
            b = $urandom;
            c = $urandom;
            d = $urandom;
        end
        send_query(logit, a, b, c, d);
    endtask

    // directed queries under the reset settings
    query_row_t directed_rows [] = '{
        '{16'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1, DROP_SMALL, 16'd32768},
        '{16'sd32767, 32'sd0, 32'sd0, 32'sd65536, 32'sd65536, 1'b0, DROP_NONE, 16'd0},
        '{-16'sd32768, 32'sd0, 32'sd0, 32'sd65536, 32'sd65536, 1'b0, DROP_NONE, 16'd0},
        '{16'sd1, 32'sd6554, 32'sd13107, 32'sd45875, 32'sd52429, 1'b0, DROP_NONE, 16'd0},
        '{-16'sd1, -32'sd32768, -32'sd32768, 32'sd98304, 32'sd98304, 1'b0, DROP_NONE, 16'd0},
        '{16'sd256, -32'sd32769, 32'sd0, 32'sd98304, 32'sd65536, 1'b0, DROP_NONE, 16'd0},
        '{16'sd512, 32'sd0, 32'sd0, 32'sd98305, 32'sd65536, 1'b0, DROP_NONE, 16'd0},
        '{-16'sd700, 32'd100 << 16, 32'd50 << 16, 32'd300 << 16, 32'd420 << 16,
          1'b0, DROP_NONE, 16'd0},
        '{16'sd1000, 32'sd32768, 32'sd32768, 32'sd16384, 32'sd32768, 1'b0, DROP_NONE, 16'd0},
        '{16'sd4095, 32'sd32768, 32'sd32768, 32'sd65536, 32'sd0, 1'b0, DROP_NONE, 16'd0},
        '{16'sd4096, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
          1'b0, DROP_NONE, 16'd0},
        '{-16'sd4097, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
          1'b0, DROP_NONE, 16'd0},
        '{16'sd300, 32'd10 << 16, 32'd10 << 16, (32'd10 << 16) + 32'sd255,
          32'd20 << 16, 1'b0, DROP_NONE, 16'd0},
        '{16'sd300, 32'd10 << 16, 32'd10 << 16, (32'd11 << 16), 32'd20 << 16,
          1'b0, DROP_NONE, 16'd0},
        '{16'sd300, -32'sd65536, -32'sd65536, -32'sd1, -32'sd1, 1'b0, DROP_NONE, 16'd0},
        '{16'sd300, 32'd600 << 16, 32'd600 << 16, 32'd900 << 16, 32'd700 << 16,
          1'b0, DROP_NONE, 16'd0}
    };

    // result side: random stall at the falling edge, check at the rising edge
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item with no query outstanding");
                error_count <= error_count + 1;
            end
            else
            begin
                result_t e;
                result_t g;
                e = pending_results.pop_front();
                g.keep = m_axis_tuser[0];
                g.reason = drop_t'(m_axis_tuser[2:1]);
                g.score = m_axis_tdata[15:0];
                g.left = m_axis_tdata[36:16];
                g.top = m_axis_tdata[57:37];
                g.width = m_axis_tdata[78:58];
                g.height = m_axis_tdata[99:79];
                g.crop_col = m_axis_tdata[109:100];
                g.crop_row = m_axis_tdata[119:110];
                g.crop_cols = m_axis_tdata[130:120];
                g.crop_rows = m_axis_tdata[141:131];
                if (g != e)
                    error_count <= error_count + 1;
                if (g.keep != e.keep)
                    $error("keep: expected %0d, got %0d", e.keep, g.keep);
                if (g.reason != e.reason)
                    $error("drop_reason: expected %0d, got %0d", e.reason, g.reason);
                if (g.score != e.score)
                    $error("score: expected %0d, got %0d", e.score, g.score);
                if (g.left != e.left)
                    $error("out_left: expected %0d, got %0d", e.left, g.left);
                if (g.top != e.top)
                    $error("out_top: expected %0d, got %0d", e.top, g.top);
                if (g.width != e.width)
                    $error("out_width: expected %0d, got %0d", e.width, g.width);
                if (g.height != e.height)
                    $error("out_height: expected %0d, got %0d", e.height, g.height);
                if (g.crop_col != e.crop_col)
                    $error("crop_col: expected %0d, got %0d", e.crop_col, g.crop_col);
                if (g.crop_row != e.crop_row)
                    $error("crop_row: expected %0d, got %0d", e.crop_row, g.crop_row);
                if (g.crop_cols != e.crop_cols)
                    $error("crop_cols: expected %0d, got %0d", e.crop_cols, g.crop_cols);
                if (g.crop_rows != e.crop_rows)
                    $error("crop_rows: expected %0d, got %0d", e.crop_rows, g.crop_rows);
                case (e.reason)
                    DROP_NONE:  kept_count <= kept_count + 1;
                    DROP_SCORE: score_drop_count <= score_drop_count + 1;
                    default:    small_drop_count <= small_drop_count + 1;
                endcase
            end
        end
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("watchdog: no item moved for %0d cycles", WatchdogLimit);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int unsigned settings [6][5];
        result_t r;
        settings = '{
            '{640, 640, 160, 160, 0},
            '{4096, 4096, 1024, 1024, 32768},
            '{1, 1, 1, 1, 0},
            '{1920, 1080, 2047, 0, 20000},
            '{8191, 0, 300, 77, 65535},
            '{320, 512, 80, 128, 65536}
        };
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_NET_WIDTH;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        kept_count = 0;
        score_drop_count = 0;
        small_drop_count = 0;
        sender_idle_pct = 19;
        receiver_idle_pct = 64;
        build_sigmoid_rom();
        net_w = 640;
        net_h = 640;
        mask_c = 160;
        mask_r = 160;
        thresh = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            query_row_t q;
            q = directed_rows[i];
            if (q.known)
            begin
                r = filter_query(q.logit, q.a, q.b, q.c, q.d);
                if (r.reason != q.known_reason || r.score != q.known_score)
                begin
                    $error("directed query %0d: predictor gives reason %0d score %0d",
                           i, r.reason, r.score);
                    error_count++;
                end
            end
            send_query(q.logit, q.a, q.b, q.c, q.d);
        end

        for (int p = 0; p < 6; p++)
        begin
            if (p == 2)
            begin
                sender_idle_pct = 64;
                receiver_idle_pct = 19;
            end
            else if (p == 4)
            begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            apply_setting(settings[p][0], settings[p][1], settings[p][2],
                          settings[p][3], settings[p][4]);
            for (int n = 0; n < ItemsPerSetting; n++)
            begin
                if (p == 0 && n == 100)
                    while (pending_results.size() != 0)
                        @(negedge clk);
                send_random_query();
            end
        end

        drain_results();
        $display("covered %0d kept, %0d score drops, %0d size drops over six settings",
                 kept_count, score_drop_count, small_drop_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: detection_query_box_filter.f
design/dqbf_pkg.sv
design/dqbf_front.sv
design/dqbf_fifo.sv
design/dqbf_back.sv
design/detection_query_box_filter.sv
tb/detection_query_box_filter_tb.sv
